[rtl/cas_pkg.sv]
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, types and command/status structs of the cave automaton
// smoother.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;

  localparam int unsigned CNT_W     = 7;
  localparam int unsigned LIM_W     = 4;
  localparam int unsigned CFG_DW    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MIN_SIZE  = 3;

  localparam logic [CNT_W-1:0] RST_ROWS  = 7'd64;
  localparam logic [CNT_W-1:0] RST_COLS  = 7'd64;
  localparam logic [LIM_W-1:0] RST_BIRTH = 4'd3;
  localparam logic [LIM_W-1:0] RST_DEATH = 4'd2;
  localparam logic [LIM_W-1:0] RST_GENS  = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 3'd0,
    CFG_COLS  = 3'd1,
    CFG_BIRTH = 3'd2,
    CFG_DEATH = 3'd3,
    CFG_GENS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GEN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  typedef enum logic [1:0] {
    WR_LOAD,
    WR_BORDER,
    WR_NEW
  } wr_sel_e;

  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    win_shift;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic             out_taken;
    logic [CNT_W-1:0] rows_eff;
    logic [LIM_W-1:0] generations;
  } status_t;

endpackage

[rtl/cas_ram.sv]
// ----------------------------------------------------------------------------
// cas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cas_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cas_datapath.sv]
// ----------------------------------------------------------------------------
// cas_datapath
// Configuration registers, grid RAM, three-row window, neighbor count logic
// and output register.
// ----------------------------------------------------------------------------
module cas_datapath #(
  parameter int unsigned MAX_ROWS = cas_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = cas_pkg::DEF_MAX_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cas_pkg::CFG_DW-1:0]      cfg_data_i,
  input  logic [MAX_COLS-1:0]             row_cells_i,
  input  cas_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(MAX_ROWS)-1:0]     rd_addr_i,
  input  logic [$clog2(MAX_ROWS)-1:0]     wr_addr_i,
  input  logic                            out_stall_i,
  output cas_pkg::status_t                status_o,
  output logic                            out_valid_o,
  output logic [MAX_COLS-1:0]             out_cells_o
);
  import cas_pkg::*;

  logic [CNT_W-1:0]    rows_q, cols_q;
  logic [LIM_W-1:0]    birth_q, death_q, gens_q;
  logic [CNT_W-1:0]    rows_eff, cols_eff;
  logic [MAX_COLS-1:0] col_mask, interior, calc, new_row, wdata, rdata;
  logic [MAX_COLS-1:0] win_above_q, win_here_q, out_cells_q;
  logic                out_valid_q, out_taken;
  logic [LIM_W-1:0]    nbr [MAX_COLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= RST_ROWS;
      cols_q  <= RST_COLS;
      birth_q <= RST_BIRTH;
      death_q <= RST_DEATH;
      gens_q  <= RST_GENS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS:  rows_q  <= cfg_data_i;
        CFG_COLS:  cols_q  <= cfg_data_i;
        CFG_BIRTH: birth_q <= cfg_data_i[LIM_W-1:0];
        CFG_DEATH: death_q <= cfg_data_i[LIM_W-1:0];
        CFG_GENS:  gens_q  <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_q < CNT_W'(MIN_SIZE)) begin
      rows_eff = CNT_W'(MIN_SIZE);
    end else if (rows_q > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_q;
    end
    if (cols_q < CNT_W'(MIN_SIZE)) begin
      cols_eff = CNT_W'(MIN_SIZE);
    end else if (cols_q > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = cols_q;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_COLS; k++) begin
      col_mask[k] = CNT_W'(k) < cols_eff;
      interior[k] = (k >= 1) && (CNT_W'(k + 1) < cols_eff);
    end
  end

  // window: above = old row r-1, here = old row r, RAM data = old row r+1
  always_comb begin
    nbr[0]            = '0;
    nbr[MAX_COLS-1]   = '0;
    calc[0]           = 1'b0;
    calc[MAX_COLS-1]  = 1'b0;
    for (int k = 1; k < MAX_COLS - 1; k++) begin
      nbr[k] = LIM_W'(win_above_q[k-1]) + LIM_W'(win_above_q[k]) + LIM_W'(win_above_q[k+1])
             + LIM_W'(win_here_q[k-1])  + LIM_W'(win_here_q[k+1])
             + LIM_W'(rdata[k-1])       + LIM_W'(rdata[k])       + LIM_W'(rdata[k+1]);
      calc[k] = win_here_q[k] ? (nbr[k] >= death_q) : (nbr[k] > birth_q);
    end
  end

  assign new_row = (calc | ~interior) & col_mask;

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_LOAD:   wdata = row_cells_i & col_mask;
      WR_BORDER: wdata = col_mask;
      WR_NEW:    wdata = new_row;
      default:   wdata = col_mask;
    endcase
  end

  cas_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_shift) begin
      win_above_q <= win_here_q;
      win_here_q  <= rdata;
    end
    if (cmd_i.out_load) begin
      out_cells_q <= rdata & col_mask;
    end
  end

  assign out_taken = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_taken   = out_taken;
  assign status_o.rows_eff    = rows_eff;
  assign status_o.generations = gens_q;
  assign out_valid_o          = out_valid_q;
  assign out_cells_o          = out_cells_q;

endmodule

[rtl/cas_ctrl.sv]
// ----------------------------------------------------------------------------
// cas_ctrl
// Sequencer for row loading, generation sweeps over the grid RAM and row
// emission.
// ----------------------------------------------------------------------------
module cas_ctrl #(
  parameter int unsigned MAX_ROWS = cas_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cas_pkg::status_t            status_i,
  output cas_pkg::cmd_t               cmd_o,
  output logic [$clog2(MAX_ROWS)-1:0] rd_addr_o,
  output logic [$clog2(MAX_ROWS)-1:0] wr_addr_o,
  output logic [$clog2(MAX_ROWS)-1:0] row_number_o,
  output logic                        final_row_o
);
  import cas_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned SW = $clog2(MAX_ROWS + 2);

  state_e           state_q, state_d;
  logic [SW-1:0]    idx_q, idx_d, idx_inc, idx_m2, rows_s, rows_p1;
  logic [LIM_W-1:0] pass_q, pass_d, pass_inc;

  assign rows_s   = SW'(status_i.rows_eff);
  assign rows_p1  = rows_s + SW'(1);
  assign idx_inc  = idx_q + SW'(1);
  assign idx_m2   = idx_q - SW'(2);
  assign pass_inc = pass_q + LIM_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      idx_q   <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    cmd_o.wr_sel = WR_LOAD;
    rd_addr_o  = AW'(idx_q);
    wr_addr_o  = AW'(idx_q);
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (idx_inc >= rows_s) begin
            idx_d   = '0;
            pass_d  = '0;
            state_d = (status_i.generations == '0) ? ST_EMIT_RD : ST_GEN;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      ST_GEN: begin
        cmd_o.rd_en     = idx_q < rows_s;
        cmd_o.win_shift = (idx_q != '0) && (idx_q <= rows_s);
        wr_addr_o       = (idx_q == SW'(1)) ? '0 : AW'(idx_m2);
        if (idx_q == SW'(1)) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_BORDER;
        end else if (idx_q >= SW'(3) && idx_q <= rows_s) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_NEW;
        end else if (idx_q == rows_p1) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_BORDER;
        end
        if (idx_q == rows_p1) begin
          idx_d  = '0;
          pass_d = pass_inc;
          if (pass_inc == status_i.generations) begin
            state_d = ST_EMIT_RD;
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (status_i.out_taken) begin
          if (idx_inc == rows_s) begin
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d       = idx_inc;
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = AW'(idx_inc);
            state_d     = ST_EMIT_LD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign row_number_o = AW'(idx_q);
  assign final_row_o  = idx_inc == rows_s;

endmodule

[rtl/cave_automaton_smoother.sv]
// ----------------------------------------------------------------------------
// cave_automaton_smoother
// Loads a binary grid row by row, runs cave automaton generations on it and
// emits the resulting rows in order.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while in_valid_i is high until rows_eff rows
// are in; the grid lives in one RAM with a registered read port. Each
// generation then sweeps the grid once through a three-row window, rewriting
// each row in place once it has passed the RAM read register and the window
// register. Rows are then read back, starting with a read state, and emitted
// one at a time, the next row being read only once the output has taken the
// current one. No input row is taken while a grid is being smoothed or
// emitted.
module cave_automaton_smoother #(
  parameter int unsigned MAX_ROWS = cas_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = cas_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cas_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [MAX_COLS-1:0]           row_cells_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [MAX_COLS-1:0]           out_cells_o,
  output logic [$clog2(MAX_ROWS)-1:0]   row_number_o,
  output logic                          final_row_o
);
  import cas_pkg::*;

  cmd_t                        cmd;
  status_t                     status;
  logic [$clog2(MAX_ROWS)-1:0] rd_addr, wr_addr;

  cas_ctrl #(
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .row_number_o(row_number_o),
    .final_row_o (final_row_o)
  );

  cas_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .row_cells_i(row_cells_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .out_stall_i(out_stall_i),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_cells_o(out_cells_o)
  );

endmodule

[rtl/cas_checker.sv]
// ----------------------------------------------------------------------------
// cas_checker
// Port-level checks of the cave automaton smoother, bound to the top level.
// ----------------------------------------------------------------------------
module cas_checker #(
  parameter int unsigned MAX_ROWS = cas_pkg::DEF_MAX_ROWS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [$clog2(MAX_ROWS)-1:0] row_number_o,
  input logic                        final_row_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS);

  logic out_beat;
  assign out_beat = out_valid_o && !out_stall_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while rows are emitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && final_row_o |=> !out_valid_o)
    else $error("output continues past the final row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !final_row_o |=>
      row_number_o == RW'($past(row_number_o) + 1'b1))
    else $error("row number does not advance by one");

endmodule

bind cave_automaton_smoother cas_checker #(
  .MAX_ROWS(MAX_ROWS)
) u_cas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .row_number_o(row_number_o),
  .final_row_o (final_row_o)
);
